@@ rtl/chm_pkg.sv @@
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash map unit
// Holds the action and status codes, the controller state type and defaults.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int unsigned DefBuckets = 256;
	localparam int unsigned DefNodes = 1024;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_FOUND     = 3'd0,
		ST_MISS      = 3'd1,
		ST_INSERTED  = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_FULL      = 3'd4,
		ST_CLEARED   = 3'd5
	} status_t;

	localparam logic [1:0] CFG_SEED = 2'd0;
	localparam logic [1:0] CFG_BUCKETS = 2'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_HEAD,
		S_NODE,
		S_WRITE,
		S_DONE
	} state_t;

endpackage

@@ rtl/chained_hash_map_unit.sv @@
// ----------------------------------------------------------------------------
// chained_hash_map_unit: key-to-data map with separate chaining
// Buckets point into a node pool; each node holds key, data and next link.
// ----------------------------------------------------------------------------
// A clear or the unused action code offers its result in the cycle after
// acceptance; lookup and insert compute the bucket remainder (one bit a
// cycle), read the bucket head and walk the chain through the registered node
// RAM before offering theirs. One transaction is handled at a time; the input
// is ready again the cycle after a result is taken.
// Reset clears the control state, the bucket valid bits and the pool count at
// once; no clearing pass is needed.
module chained_hash_map_unit #(
	parameter int unsigned BUCKETS = chm_pkg::DefBuckets,
	parameter int unsigned NODES = chm_pkg::DefNodes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic signed [31:0] key,
	input  logic signed [31:0] data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic signed [31:0] read_data,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int CW = $clog2(NODES + 1);

	// Configuration registers.
	logic [31:0] seed_q;
	logic [8:0]  bcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= '0;
			bcount_q <= 9'd256;
		end else if (cfg_we) begin
			if ({1'b0, cfg_index} == chm_pkg::CFG_SEED) begin
				seed_q <= cfg_data;
			end else begin
				bcount_q <= cfg_data[8:0];
			end
		end
	end

	// The divisor is clamped to one through BUCKETS.
	logic [16:0] divisor;
	always_comb begin
		if (bcount_q == 9'd0) begin
			divisor = 17'd1;
		end else if (32'(bcount_q) > BUCKETS) begin
			divisor = 17'(BUCKETS);
		end else begin
			divisor = {8'd0, bcount_q};
		end
	end

	// Captured transaction.
	chm_pkg::state_t state_q, state_d;
	chm_pkg::action_t act_q;
	logic [31:0] key_q, data_q;
	logic [BW-1:0] bucket_q;
	logic [NW-1:0] node_q, tail_q;
	logic          have_tail_q;
	logic [CW-1:0] free_q;
	logic [0:0]    steps_q;
	logic [2:0]    status_q;
	logic [31:0]   rdata_q;

	// Magnitude of the key, XORed with the seed. The divider latches its
	// dividend in the accepting cycle, so it is taken from the input port.
	logic [31:0] mag;
	assign mag = key[31] ? (32'd0 - key) : key;

	logic        div_start, div_done;
	logic [16:0] remainder;

	chm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag ^ seed_q),
		.divisor  (divisor),
		.done     (div_done),
		.remainder(remainder)
	);

	// Bucket heads: valid bits in flip-flops, indices in a small RAM.
	logic [BUCKETS-1:0] head_vld_q;
	logic [NW-1:0] head_mem [BUCKETS];
	logic [NW-1:0] head_rd;

	// Node store: key, value, link valid and link index in one wide RAM.
	localparam int NDW = 64 + 1 + NW;
	logic [NDW-1:0] node_mem [NODES];
	logic [NDW-1:0] node_rd;
	logic           node_we;
	logic [NW-1:0]  node_wa;
	logic [NDW-1:0] node_wd;
	logic [NW-1:0]  node_ra;

	// Tail link update goes through the same write port in the cycle after the
	// new node is written; it lands in the first cycle of S_DONE.
	logic tail_pend_q;
	logic [NDW-1:0] tail_word_q;

	logic [31:0]   rd_key, rd_val;
	logic          rd_lv;
	logic [NW-1:0] rd_li;
	assign rd_key = node_rd[NDW-1 -: 32];
	assign rd_val = node_rd[NDW-33 -: 32];
	assign rd_lv  = node_rd[NW];
	assign rd_li  = node_rd[NW-1:0];

	// The head read follows the fresh remainder so the head index is ready
	// in S_HEAD.
	always_ff @(posedge clk) begin
		head_rd <= head_mem[div_done ? remainder[BW-1:0] : bucket_q];
		node_rd <= node_mem[node_ra];
		if (node_we) begin
			node_mem[node_wa] <= node_wd;
		end else if (tail_pend_q) begin
			node_mem[tail_q] <= tail_word_q;
		end
	end

	logic head_we;
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[bucket_q] <= free_q[NW-1:0];
		end
	end

	logic accept;
	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == chm_pkg::S_IDLE);

	logic key_hit, chain_more;
	assign key_hit = (rd_key == key_q);
	assign chain_more = rd_lv;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chm_pkg::S_IDLE: begin
				if (accept) begin
					if (chm_pkg::action_t'(action) == chm_pkg::ACT_LOOKUP ||
					    chm_pkg::action_t'(action) == chm_pkg::ACT_INSERT) begin
						state_d = chm_pkg::S_DIV;
					end else begin
						state_d = chm_pkg::S_DONE;
					end
				end
			end
			chm_pkg::S_DIV: if (div_done) state_d = chm_pkg::S_HEAD;
			chm_pkg::S_HEAD: begin
				if (!head_vld_q[bucket_q]) state_d = chm_pkg::S_WRITE;
				else state_d = chm_pkg::S_NODE;
			end
			chm_pkg::S_NODE: begin
				if (steps_q[0] && (key_hit || !chain_more)) state_d = chm_pkg::S_WRITE;
			end
			chm_pkg::S_WRITE: state_d = chm_pkg::S_DONE;
			chm_pkg::S_DONE: if (out_ready) state_d = chm_pkg::S_IDLE;
			default: state_d = chm_pkg::S_IDLE;
		endcase
	end

	// In S_NODE, steps_q[0] low marks the cycle that issues the read.
	logic found_q;
	logic ins_ok;
	assign ins_ok = (act_q == chm_pkg::ACT_INSERT) && !found_q &&
	                (free_q < CW'(NODES));

	always_comb begin
		div_start = (state_q == chm_pkg::S_IDLE) && accept;
		node_ra   = node_q;
		node_we   = (state_q == chm_pkg::S_WRITE) && ins_ok;
		node_wa   = free_q[NW-1:0];
		node_wd   = {key_q, data_q, 1'b0, {NW{1'b0}}};
		head_we   = node_we && !have_tail_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chm_pkg::S_IDLE;
			head_vld_q  <= '0;
			free_q      <= '0;
			tail_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tail_pend_q <= 1'b0;
			if (accept && chm_pkg::action_t'(action) == chm_pkg::ACT_CLEAR) begin
				head_vld_q <= '0;
				free_q     <= '0;
			end
			if (node_we) begin
				free_q <= free_q + CW'(1);
				if (!have_tail_q) head_vld_q[bucket_q] <= 1'b1;
				else tail_pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= chm_pkg::action_t'(action);
			key_q    <= key;
			data_q   <= data;
			found_q  <= 1'b0;
			have_tail_q <= 1'b0;
			steps_q  <= '0;
		end
		if (div_done) begin
			bucket_q <= remainder[BW-1:0];
		end
		if (state_q == chm_pkg::S_HEAD) begin
			node_q  <= head_rd;
			steps_q <= '0;
		end
		if (state_q == chm_pkg::S_NODE) begin
			steps_q <= steps_q + 1'b1;
			if (steps_q[0]) begin
				if (key_hit) begin
					found_q <= 1'b1;
					rdata_q <= rd_val;
				end else begin
					have_tail_q <= 1'b1;
					tail_q      <= node_q;
					tail_word_q <= {rd_key, rd_val, 1'b1, free_q[NW-1:0]};
					node_q      <= rd_li;
				end
			end
		end
		if (state_q == chm_pkg::S_WRITE || (state_q == chm_pkg::S_IDLE && accept)) begin
			if (state_q == chm_pkg::S_IDLE) begin
				status_q <= (chm_pkg::action_t'(action) == chm_pkg::ACT_CLEAR) ?
				            chm_pkg::ST_CLEARED : chm_pkg::ST_MISS;
				rdata_q  <= (chm_pkg::action_t'(action) == chm_pkg::ACT_CLEAR) ?
				            32'd0 : 32'hFFFF_FFFF;
			end else if (act_q == chm_pkg::ACT_LOOKUP) begin
				status_q <= found_q ? chm_pkg::ST_FOUND : chm_pkg::ST_MISS;
				if (!found_q) rdata_q <= 32'hFFFF_FFFF;
			end else begin
				rdata_q <= 32'd0;
				if (found_q) status_q <= chm_pkg::ST_DUPLICATE;
				else if (free_q >= CW'(NODES)) status_q <= chm_pkg::ST_FULL;
				else status_q <= chm_pkg::ST_INSERTED;
			end
		end
	end

	assign out_valid = (state_q == chm_pkg::S_DONE);
	assign status    = status_q;
	assign read_data = rdata_q;

endmodule

@@ rtl/chm_divider.sv @@
// ----------------------------------------------------------------------------
// chm_divider: restoring remainder unit
// Computes a 32-bit dividend modulo a 17-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module chm_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [16:0] divisor,
	output logic        done,
	output logic [16:0] remainder
);

	logic [31:0] shift_q;
	logic [16:0] rem_q;
	logic [16:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [17:0] trial;

	assign trial = {rem_q, shift_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
			div_q   <= divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[30:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= 17'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[16:0];
			end
		end
	end

	assign remainder = rem_q;

endmodule

@@ rtl/chm_checker.sv @@
// ----------------------------------------------------------------------------
// chm_checker: port-level checks of the chained hash map unit
// Watches the handshakes and the result codes seen on the top level.
// ----------------------------------------------------------------------------
module chm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  action,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [31:0] read_data
);

	// A result stays offered until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped before transaction");

	// A clear answers with the cleared code on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == chm_pkg::ACT_CLEAR |=>
		out_valid && status == chm_pkg::ST_CLEARED)
		else $error("clear did not report cleared");

	// No input is taken while a result is pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken during pending result");

	// Insert codes carry zero data.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == chm_pkg::ST_INSERTED || status == chm_pkg::ST_FULL ||
		status == chm_pkg::ST_DUPLICATE) |-> read_data == 32'd0)
		else $error("nonzero data on insert result");

endmodule

bind chained_hash_map_unit chm_checker u_chm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.action   (action),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status   (status),
	.read_data(read_data)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the chained hash map unit
// Random and directed lookups, inserts and clears go through a shadow table
// kept in the bench, and every result is compared against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		chm_pkg::action_t   act;
		logic signed [31:0] key;
		logic signed [31:0] data;
	} map_op_t;

	typedef struct {
		chm_pkg::status_t st;
		logic [31:0]      rd;
	} map_reply_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         action;
	logic signed [31:0] key;
	logic signed [31:0] data;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         status;
	logic signed [31:0] read_data;
	logic               cfg_we;
	logic [0:0]         cfg_index;
	logic [31:0]        cfg_data;

	chained_hash_map_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .key(key), .data(data),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .read_data(read_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the table: bucket heads, node store and pool count.
	logic        sh_head_v[256];
	logic [10:0] sh_head_i[256];
	logic [31:0] sh_key[1024];
	logic [31:0] sh_val[1024];
	logic        sh_link_v[1024];
	logic [10:0] sh_link_i[1024];
	int unsigned sh_used;
	logic [31:0] sh_seed;
	logic [8:0]  sh_buckets;

	map_op_t     pending_ops[$];
	map_reply_t  expected_replies[$];
	logic [31:0] known_keys[$];
	int          errors;
	int          sender_idle;
	int          receiver_idle;
	logic        hold_start;
	int          hold_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Timeout guard, sized well above the slowest legal run.
	initial begin
		#15ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int unsigned bucket_index(logic [31:0] k);
		logic [31:0] mag;
		int unsigned div;
		mag = k[31] ? (32'd0 - k) : k;
		// A divisor of zero acts as one; anything above the table size is clamped.
		div = (sh_buckets == 0) ? 1 : ((sh_buckets > 256) ? 256 : sh_buckets);
		return ((mag ^ sh_seed) % div) % 256;
	endfunction

	// Applies one operation to the shadow table and returns the predicted reply.
	function automatic map_reply_t shadow_apply(map_op_t op);
		map_reply_t r;
		int unsigned b;
		int unsigned n;
		int unsigned tail;
		int unsigned hit;
		logic v;
		logic have_tail;
		logic found;
		r.st = chm_pkg::ST_MISS;
		r.rd = 32'hFFFF_FFFF;
		if (op.act == chm_pkg::ACT_CLEAR) begin
			foreach (sh_head_v[i]) sh_head_v[i] = 1'b0;
			sh_used = 0;
			r.st = chm_pkg::ST_CLEARED;
			r.rd = 32'd0;
		end else if (op.act == chm_pkg::ACT_LOOKUP || op.act == chm_pkg::ACT_INSERT) begin
			b = bucket_index(op.key);
			v = sh_head_v[b];
			n = {21'd0, sh_head_i[b]};
			have_tail = 1'b0;
			found = 1'b0;
			tail = 0;
			hit = 0;
			for (int s = 0; v && s < 1024; s++) begin
				if (n >= 1024) break;
				if (sh_key[n] == op.key) begin
					found = 1'b1;
					hit = n;
					break;
				end
				have_tail = 1'b1;
				tail = n;
				v = sh_link_v[n];
				n = {21'd0, sh_link_i[n]};
			end
			if (op.act == chm_pkg::ACT_LOOKUP) begin
				if (found) begin
					r.st = chm_pkg::ST_FOUND;
					r.rd = sh_val[hit];
				end
			end else begin
				r.rd = 32'd0;
				// A duplicate wins over a full pool.
				if (found) r.st = chm_pkg::ST_DUPLICATE;
				else if (sh_used >= 1024) r.st = chm_pkg::ST_FULL;
				else begin
					sh_key[sh_used] = op.key;
					sh_val[sh_used] = op.data;
					sh_link_v[sh_used] = 1'b0;
					sh_link_i[sh_used] = '0;
					if (have_tail) begin
						sh_link_v[tail] = 1'b1;
						sh_link_i[tail] = 11'(sh_used);
					end else begin
						sh_head_v[b] = 1'b1;
						sh_head_i[b] = 11'(sh_used);
					end
					sh_used++;
					r.st = chm_pkg::ST_INSERTED;
				end
			end
		end
		return r;
	endfunction

	// Driver: predicts on each accepted transaction, then offers the next one.
	always @(posedge clk or negedge arst_n) begin
		map_op_t op;
		logic next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= chm_pkg::ACT_LOOKUP;
			key <= '0;
			data <= '0;
		end else begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				op.act = chm_pkg::action_t'(action);
				op.key = key;
				op.data = data;
				expected_replies.push_back(shadow_apply(op));
				next_valid = 1'b0;
			end
			if (!next_valid && pending_ops.size() > 0 &&
					$urandom_range(99) >= sender_idle) begin
				op = pending_ops.pop_front();
				action <= op.act;
				key <= op.key;
				data <= op.data;
				next_valid = 1'b1;
			end
			in_valid <= next_valid;
		end
	end

	// Long receiver hold-off, counted down on its own.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
		end else if (hold_start) begin
			hold_cnt <= 400;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// Monitor: checks each accepted result against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		map_reply_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: result with nothing expected: status %0d data %h",
						$time, status, read_data);
					errors++;
				end else begin
					exp_r = expected_replies.pop_front();
					if (status !== exp_r.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_r.st, status);
						errors++;
					end
					if (read_data !== exp_r.rd) begin
						$display("%0t: read_data expected %h actual %h",
							$time, exp_r.rd, read_data);
						errors++;
					end
				end
			end
			out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= receiver_idle);
		end
	end

	task automatic push_op(chm_pkg::action_t a, logic [31:0] k, logic [31:0] d);
		map_op_t op;
		op.act = a;
		op.key = k;
		op.data = d;
		pending_ops.push_back(op);
		if (a == chm_pkg::ACT_INSERT) known_keys.push_back(k);
		if (a == chm_pkg::ACT_CLEAR) known_keys.delete();
	endtask

	// Sender pause: nothing more is offered until every result has come back.
	task automatic drain;
		while (pending_ops.size() != 0 || in_valid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx[0:0];
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == chm_pkg::CFG_SEED) sh_seed = val;
		else sh_buckets = val[8:0];
	endtask

	function automatic logic [31:0] pick_key();
		int unsigned r;
		r = $urandom_range(99);
		if (known_keys.size() > 0 && r < 45)
			return known_keys[$urandom_range(known_keys.size() - 1)];
		if (r < 55) begin
			case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'hFFFF_FFFF;
				default: return 32'd0;
			endcase
		end
		if (r < 75) return $urandom_range(600);
		return $urandom;
	endfunction

	// Mostly inserts and lookups on overlapping keys, a few clears and dead codes.
	task automatic random_ops(int count, bit with_clear);
		int unsigned r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (with_clear && r < 3) push_op(chm_pkg::ACT_CLEAR, $urandom, $urandom);
			else if (r < 6) push_op(chm_pkg::ACT_NONE, pick_key(), $urandom);
			else if (r < 50) push_op(chm_pkg::ACT_LOOKUP, pick_key(), $urandom);
			else push_op(chm_pkg::ACT_INSERT, pick_key(), $urandom);
		end
	endtask

	initial begin
		errors = 0;
		sh_seed = '0;
		sh_buckets = 9'd256;
		sh_used = 0;
		foreach (sh_head_v[i]) begin
			sh_head_v[i] = 1'b0;
			sh_head_i[i] = '0;
		end
		foreach (sh_key[i]) begin
			sh_key[i] = '0;
			sh_val[i] = '0;
			sh_link_v[i] = 1'b0;
			sh_link_i[i] = '0;
		end
		hold_start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sender_idle = 38;
		receiver_idle = 62;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, field extremes, keys sharing a magnitude,
		// duplicates, the unused action code and a clear.
		push_op(chm_pkg::ACT_LOOKUP, 32'd5, 32'd0);
		push_op(chm_pkg::ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
		push_op(chm_pkg::ACT_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
		push_op(chm_pkg::ACT_INSERT, 32'd0, 32'd0);
		push_op(chm_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(chm_pkg::ACT_INSERT, 32'd1, 32'h1234_5678);
		push_op(chm_pkg::ACT_LOOKUP, 32'h8000_0000, 32'd0);
		push_op(chm_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 32'd0);
		push_op(chm_pkg::ACT_LOOKUP, 32'd0, 32'd0);
		push_op(chm_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'd0);
		push_op(chm_pkg::ACT_LOOKUP, 32'd1, 32'd0);
		push_op(chm_pkg::ACT_INSERT, 32'd1, 32'hDEAD_BEEF);
		push_op(chm_pkg::ACT_LOOKUP, 32'd1, 32'd0);
		push_op(chm_pkg::ACT_INSERT, 32'd257, 32'd9);
		push_op(chm_pkg::ACT_LOOKUP, 32'd257, 32'd0);
		push_op(chm_pkg::ACT_NONE, 32'd1, 32'd1);
		push_op(chm_pkg::ACT_CLEAR, 32'd0, 32'd0);
		push_op(chm_pkg::ACT_LOOKUP, 32'd1, 32'd0);
		push_op(chm_pkg::ACT_INSERT, 32'd1, 32'd77);
		push_op(chm_pkg::ACT_LOOKUP, 32'd1, 32'd0);
		random_ops(80, 1'b1);
		drain();

		// Single bucket: every key lands on one chain, kept short on purpose.
		sender_idle = 62;
		receiver_idle = 38;
		write_reg(chm_pkg::CFG_BUCKETS, 32'd1);
		push_op(chm_pkg::ACT_CLEAR, 32'd0, 32'd0);
		random_ops(60, 1'b0);
		drain();

		// Divisor of zero, then a change of divisor with entries still held.
		write_reg(chm_pkg::CFG_BUCKETS, 32'd0);
		write_reg(chm_pkg::CFG_SEED, 32'hA5A5_0F0F);
		random_ops(30, 1'b0);
		drain();
		write_reg(chm_pkg::CFG_BUCKETS, 32'd37);
		random_ops(40, 1'b0);
		drain();

		// Fill the whole pool with no idling, then hit it with more inserts.
		sender_idle = 0;
		receiver_idle = 0;
		write_reg(chm_pkg::CFG_BUCKETS, 32'd511);
		write_reg(chm_pkg::CFG_SEED, 32'hFFFF_FFFF);
		push_op(chm_pkg::ACT_CLEAR, 32'd0, 32'd0);
		for (int i = 0; i < 1150; i++) begin
			if (i % 20 == 19 && known_keys.size() > 0)
				push_op(chm_pkg::ACT_LOOKUP,
					known_keys[$urandom_range(known_keys.size() - 1)], 32'd0);
			else if (i % 97 == 50)
				push_op(chm_pkg::ACT_INSERT,
					known_keys[$urandom_range(known_keys.size() - 1)], $urandom);
			else push_op(chm_pkg::ACT_INSERT, $urandom, $urandom);
		end
		// The receiver holds off for a long stretch while the sender keeps offering items.
		@(posedge clk);
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		drain();

		// Back to default registers, still with no idling.
		write_reg(chm_pkg::CFG_SEED, 32'd0);
		write_reg(chm_pkg::CFG_BUCKETS, 32'd256);
		random_ops(40, 1'b1);
		drain();

		repeat (50) @(posedge clk);
		if (errors == 0 && expected_replies.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
